@@ src/fcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the framed command decoder
// Keyword table, response codes, frame phases and the structs passed
// between the frame receiver, the flag logic and the output stage.
// ----------------------------------------------------------------------------
package fcd_pkg;

    // Payload capacity and the width of the payload length counter
    localparam int PACKET_MAX = 32;
    localparam int LEN_W      = $clog2(PACKET_MAX + 1);

    // Keyword table geometry
    localparam int KW_COUNT  = 13;
    localparam int KW_MAXLEN = 16;
    localparam int KW_POS_W  = $clog2(KW_MAXLEN);

    // Config port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int DIST_W     = 10;
    localparam int SPEED_W    = 4;

    // Frame delimiters
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    // Reset values of the config registers and of the speed level
    localparam logic [DIST_W-1:0]  NEAR_RST         = 10'd15;
    localparam logic [DIST_W-1:0]  FAR_RST          = 10'd20;
    localparam logic [SPEED_W-1:0] SPEED_NORMAL_RST = 4'd7;
    localparam logic [SPEED_W-1:0] SPEED_MAX_RST    = 4'd9;
    localparam logic [SPEED_W-1:0] SPEED_FOLLOW_RST = 4'd4;

    typedef enum logic [3:0] {
        CODE_UNKNOWN     = 4'd0,
        CODE_W           = 4'd1,
        CODE_S           = 4'd2,
        CODE_A           = 4'd3,
        CODE_D           = 4'd4,
        CODE_ON          = 4'd5,
        CODE_OFF         = 4'd6,
        CODE_SUDU1       = 4'd7,
        CODE_SUDU2       = 4'd8,
        CODE_GENSUI      = 4'd9,
        CODE_GENSUI_STOP = 4'd10,
        CODE_STOP        = 4'd11,
        CODE_ZZSTOP      = 4'd12,
        CODE_ZHUANGTAI   = 4'd13,
        CODE_DISTANCE    = 4'd14
    } t_code;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_TAIL = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR         = 3'd0,
        CFG_FAR          = 3'd1,
        CFG_SPEED_NORMAL = 3'd2,
        CFG_SPEED_MAX    = 3'd3,
        CFG_SPEED_FOLLOW = 3'd4
    } t_cfg_idx;

    // End-of-frame event from the receiver
    typedef struct packed {
        logic  done;
        logic  overlong;
        t_code code;
    } t_frame_evt;

    // One result transaction
    typedef struct packed {
        t_code              code;
        logic               forward;
        logic               backward;
        logic               turn_left;
        logic               turn_right;
        logic               motor_stop;
        logic               motor_on;
        logic               follow_mode;
        logic [SPEED_W-1:0] speed_level;
        logic               brake_request;
        logic               overlong;
    } t_result;

    // Keyword text, right-justified, first character highest
    localparam logic [8*KW_MAXLEN-1:0] KW_STR [KW_COUNT] = '{
        128'("LANYA_W"), 128'("LANYA_S"), 128'("LANYA_A"), 128'("LANYA_D"),
        128'({"LANYA_", "ON"}), 128'({"LANYA_", "OFF"}), 128'({"LANYA_", "SUDU1"}),
        128'({"LANYA_", "SUDU2"}), 128'({"LANYA_", "GENSUI"}),
        128'({"LANYAGENSUI", "_STOP"}),
        128'("LANYASTOP"), 128'("LANYAZZSTOP"), 128'({"LANYA_", "ZHUANGTAI"})
    };

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd7, 5'd7, 5'd7, 5'd7, 5'd8, 5'd9, 5'd11,
        5'd11, 5'd12, 5'd16, 5'd9, 5'd11, 5'd15
    };

    // Character at position pos of keyword k; zero past its end
    function automatic logic [7:0] kw_byte(input logic [3:0] k,
                                           input logic [KW_POS_W-1:0] pos);
        int                        sh;
        logic [8*KW_MAXLEN-1:0]    str;
        sh  = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        str = KW_STR[k];
        if (sh < 0) begin
            return 8'h00;
        end
        return 8'(str >> sh);
    endfunction

endpackage

@@ src/framed_command_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_decoder: framed serial command decoder with follow mode
// The result of an accepted closing line feed or distance sample is
//   registered; throughput: one transaction per cycle while not stalled.
// The input stalls only when the output register and its skid stage are full.
// Reset (synchronous, active low) returns framing to wait-for-start, clears
// all flags, sets speed level 7 and loads the config registers' defaults.
// ----------------------------------------------------------------------------
module framed_command_decoder
    import fcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic [7:0]            i_rx_byte,
    input  logic [DIST_W-1:0]     i_distance_cm,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_response_code,
    output logic                  o_forward,
    output logic                  o_backward,
    output logic                  o_turn_left,
    output logic                  o_turn_right,
    output logic                  o_motor_stop,
    output logic                  o_motor_on,
    output logic                  o_follow_mode,
    output logic [SPEED_W-1:0]    o_speed_level,
    output logic                  o_brake_request,
    output logic                  o_overlong
);

    logic       accept;
    t_frame_evt evt;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign accept = i_valid && !o_stall;

    fcd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (accept && !i_command),
        .i_byte       (i_rx_byte),
        .o_evt        (evt)
    );

    fcd_flags u_flags (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt),
        .i_dist_valid (accept && i_command),
        .i_distance   (i_distance_cm),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    fcd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (out_res),
        .o_in_stall (o_stall)
    );

    // Result fields
    assign o_response_code = out_res.code;
    assign o_forward       = out_res.forward;
    assign o_backward      = out_res.backward;
    assign o_turn_left     = out_res.turn_left;
    assign o_turn_right    = out_res.turn_right;
    assign o_motor_stop    = out_res.motor_stop;
    assign o_motor_on      = out_res.motor_on;
    assign o_follow_mode   = out_res.follow_mode;
    assign o_speed_level   = out_res.speed_level;
    assign o_brake_request = out_res.brake_request;
    assign o_overlong      = out_res.overlong;

    // Skid stage only fills behind a held result
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result on the output");

    // Every distance sample yields a result
    a_dist_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command) |=> o_valid)
        else $error("distance sample lost");

    // Distance results never carry the overlong flag
    a_dist_not_overlong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_response_code == CODE_DISTANCE)) |-> !o_overlong)
        else $error("distance result flagged overlong");

endmodule

@@ src/fcd_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_frame: frame receiver and keyword matcher
// Tracks '@' payload '#' '\n' framing. Instead of buffering the payload,
// one candidate bit per keyword is narrowed as each byte arrives.
// ----------------------------------------------------------------------------
module fcd_frame
    import fcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_byte,
    output t_frame_evt o_evt
);

    t_phase               r_phase, n_phase;
    logic [LEN_W-1:0]     r_len,   n_len;
    logic                 r_ovf,   n_ovf;
    logic [KW_COUNT-1:0]  r_cand,  n_cand;
    t_code                match_code;

    // Keyword hit: candidate still alive and length exact, lowest index wins
    always_comb begin
        match_code = CODE_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_cand[k] && (r_len == LEN_W'(KW_LEN[k]))) begin
                match_code = t_code'(4'(k + 1));
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_cand  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_cand  <= n_cand;
        end
    end

    // Next state and end-of-frame event
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_cand  = r_cand;
        o_evt   = '{done: 1'b0, overlong: 1'b0, code: CODE_UNKNOWN};
        if (i_byte_valid) begin
            case (r_phase)
                PH_BODY: begin
                    if (i_byte == CH_HASH) begin
                        n_phase = PH_TAIL;
                    end else if (r_len < LEN_W'(PACKET_MAX)) begin
                        n_len = r_len + 1'b1;
                        for (int k = 0; k < KW_COUNT; k++) begin
                            n_cand[k] = r_cand[k] && (r_len < LEN_W'(KW_LEN[k])) &&
                                        (i_byte == kw_byte(4'(k), KW_POS_W'(r_len)));
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                PH_TAIL: begin
                    // only the line feed closes; other bytes are dropped
                    if (i_byte == CH_LF) begin
                        n_phase        = PH_IDLE;
                        o_evt.done     = 1'b1;
                        o_evt.overlong = r_ovf;
                        o_evt.code     = r_ovf ? CODE_UNKNOWN : match_code;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == CH_AT) begin
                        n_phase = PH_BODY;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                        n_cand  = '1;
                    end
                end
            endcase
        end
    end

endmodule

@@ src/fcd_flags.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_flags: config registers, control flags and result formatting
// Applies a decoded keyword or a distance sample to the flags and builds
// the result transaction from the updated flags.
// ----------------------------------------------------------------------------
module fcd_flags
    import fcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_frame_evt            i_evt,
    input  logic                  i_dist_valid,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_valid,
    output t_result               o_res
);

    // Config registers
    logic [DIST_W-1:0]  r_near, r_far;
    logic [SPEED_W-1:0] r_speed_normal, r_speed_max, r_speed_follow;

    // Control flags; dir bit0 forward, bit1 backward, bit2 left, bit3 right
    logic [3:0]         r_dir,    n_dir;
    logic               r_stop,   n_stop;
    logic               r_on,     n_on;
    logic               r_follow, n_follow;
    logic [SPEED_W-1:0] r_speed,  n_speed;
    logic               r_brake,  n_brake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near         <= NEAR_RST;
            r_far          <= FAR_RST;
            r_speed_normal <= SPEED_NORMAL_RST;
            r_speed_max    <= SPEED_MAX_RST;
            r_speed_follow <= SPEED_FOLLOW_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEAR:         r_near         <= i_cfg_data;
                CFG_FAR:          r_far          <= i_cfg_data;
                CFG_SPEED_NORMAL: r_speed_normal <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_MAX:    r_speed_max    <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_FOLLOW: r_speed_follow <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= '0;
            r_stop   <= 1'b0;
            r_on     <= 1'b0;
            r_follow <= 1'b0;
            r_speed  <= SPEED_NORMAL_RST;
            r_brake  <= 1'b0;
        end else begin
            r_dir    <= n_dir;
            r_stop   <= n_stop;
            r_on     <= n_on;
            r_follow <= n_follow;
            r_speed  <= n_speed;
            r_brake  <= n_brake;
        end
    end

    // Flag update
    always_comb begin
        n_dir    = r_dir;
        n_stop   = r_stop;
        n_on     = r_on;
        n_follow = r_follow;
        n_speed  = r_speed;
        n_brake  = r_brake;
        if (i_dist_valid) begin
            if (r_follow) begin
                if ((i_distance <= r_far) && (i_distance >= r_near)) begin
                    n_dir = 4'b0000;
                end else if (i_distance > r_far) begin
                    n_dir = 4'b0001;
                end else if (i_distance < r_near) begin
                    n_dir = 4'b0010;
                end
            end
        end else if (i_evt.done && !i_evt.overlong) begin
            case (i_evt.code)
                CODE_W:  n_dir = 4'b0001;
                CODE_S:  n_dir = 4'b0010;
                CODE_A:  n_dir = 4'b0100;
                CODE_D:  n_dir = 4'b1000;
                CODE_ON: begin
                    n_stop = 1'b0;
                    n_on   = 1'b1;
                end
                CODE_OFF: begin
                    n_stop = 1'b1;
                    n_on   = 1'b0;
                end
                CODE_SUDU1:  n_speed = r_speed_normal;
                CODE_SUDU2:  n_speed = r_speed_max;
                CODE_GENSUI: begin
                    n_follow = 1'b1;
                    n_speed  = r_speed_follow;
                end
                CODE_GENSUI_STOP: begin
                    n_follow = 1'b0;
                    n_speed  = r_speed_normal;
                    n_brake  = 1'b1;
                end
                CODE_STOP: begin
                    n_brake = 1'b1;
                    n_dir   = 4'b0000;
                end
                CODE_ZZSTOP: n_dir = 4'b0000;
                default: ;
            endcase
        end
    end

    // Result transaction reports the flags after the update
    always_comb begin
        o_res_valid         = i_dist_valid || i_evt.done;
        o_res.code          = i_dist_valid ? CODE_DISTANCE : i_evt.code;
        o_res.forward       = n_dir[0];
        o_res.backward      = n_dir[1];
        o_res.turn_left     = n_dir[2];
        o_res.turn_right    = n_dir[3];
        o_res.motor_stop    = n_stop;
        o_res.motor_on      = n_on;
        o_res.follow_mode   = n_follow;
        o_res.speed_level   = n_speed;
        o_res.brake_request = n_brake;
        o_res.overlong      = !i_dist_valid && i_evt.overlong;
    end

endmodule

@@ src/fcd_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_outq: result register with skid stage
// Holds the result shown on the output and one more, so that the input
// side can still take a transaction while the output is stalled.
// ----------------------------------------------------------------------------
module fcd_outq
    import fcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_in_stall
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Refill order: skid first, then the new result
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_load;
                n_skid       = i_res;
            end
        end else if (!r_out_valid || take) begin
            n_out_valid = i_load;
            n_out       = i_res;
        end else if (i_load) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res      = r_out;
    assign o_in_stall = r_skid_valid;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the framed command decoder
// Feeds serial bytes and distance samples with random bursts and gaps while
// the result side stalls on its own pattern. A behavioral decoder predicts
// every result transaction; results are compared field by field in order.
// A short directed table comes first, then random frames over several
// threshold and speed settings written between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import fcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 224;

    localparam logic [3:0] STEER_FWD  = 4'b0001;
    localparam logic [3:0] STEER_BACK = 4'b0010;
    localparam logic [3:0] STEER_LEFT = 4'b0100;
    localparam logic [3:0] STEER_RGHT = 4'b1000;

    typedef enum logic [1:0] {
        ROW_BYTE,   // single byte, low byte of text
        ROW_DIST,   // distance sample
        ROW_FRAME,  // '@' text '#' '\n'
        ROW_LONG    // frame of len copies of the low byte of text
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [127:0]        text;
        logic [5:0]          len;
        logic                junk;   // stray byte between '#' and '\n'
        logic                split;  // distance sample inside the payload
        logic [DIST_W-1:0]   dist_cm;
        logic                typed;  // code and overlong below are checked
        t_code               code;
        logic                ovl;
    } t_stim_row;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_command = 1'b0;
    logic [7:0]            i_rx_byte = '0;
    logic [DIST_W-1:0]     i_distance_cm = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [3:0]            o_response_code;
    logic                  o_forward;
    logic                  o_backward;
    logic                  o_turn_left;
    logic                  o_turn_right;
    logic                  o_motor_stop;
    logic                  o_motor_on;
    logic                  o_follow_mode;
    logic [SPEED_W-1:0]    o_speed_level;
    logic                  o_brake_request;
    logic                  o_overlong;

    framed_command_decoder dut (.*);

    always #10 i_clk = ~i_clk;

    string keyword_text [KW_COUNT] = '{
        "LANYA_W", "LANYA_S", "LANYA_A", "LANYA_D", {"LANYA_", "ON"}, {"LANYA_", "OFF"},
        {"LANYA_", "SUDU1"}, {"LANYA_", "SUDU2"}, {"LANYA_", "GENSUI"},
        {"LANYAGENSUI", "_STOP"}, "LANYASTOP", "LANYAZZSTOP", {"LANYA_", "ZHUANGTAI"}
    };

    // Directed table: reset values, every keyword, window edges, odd frames
    t_stim_row directed_rows [25] = '{
        '{ROW_BYTE,  128'("Z"),           6'd0,  1'b0, 1'b0, 10'd0,    1'b0, CODE_UNKNOWN,
          1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd0,    1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_FRAME, 128'("LANYA_W"),     6'd7,  1'b0, 1'b0, 10'd0,    1'b1, CODE_W, 1'b0},
        '{ROW_FRAME, 128'("LANYA_S"),     6'd7,  1'b0, 1'b0, 10'd0,    1'b1, CODE_S, 1'b0},
        '{ROW_FRAME, 128'("LANYA_A"),     6'd7,  1'b0, 1'b0, 10'd0,    1'b1, CODE_A, 1'b0},
        '{ROW_FRAME, 128'("LANYA_D"),     6'd7,  1'b0, 1'b0, 10'd0,    1'b1, CODE_D, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "ON"}), 6'd8, 1'b0, 1'b0, 10'd0,  1'b1, CODE_ON, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "OFF"}), 6'd9, 1'b0, 1'b0, 10'd0, 1'b1, CODE_OFF, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "SUDU1"}), 6'd11, 1'b0, 1'b0, 10'd0, 1'b1,
          CODE_SUDU1, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "SUDU2"}), 6'd11, 1'b0, 1'b0, 10'd0, 1'b1,
          CODE_SUDU2, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "GENSUI"}), 6'd12, 1'b0, 1'b0, 10'd0, 1'b1,
          CODE_GENSUI, 1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd1023, 1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd0,    1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd15,   1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd21,   1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_DIST,  128'(0),             6'd0,  1'b0, 1'b0, 10'd14,   1'b1, CODE_DISTANCE,
          1'b0},
        '{ROW_FRAME, 128'({"LANYAGENSUI", "_STOP"}), 6'd16, 1'b0, 1'b0, 10'd0, 1'b1,
          CODE_GENSUI_STOP, 1'b0},
        '{ROW_FRAME, 128'("LANYASTOP"),   6'd9,  1'b0, 1'b0, 10'd0,    1'b1, CODE_STOP, 1'b0},
        '{ROW_FRAME, 128'("LANYAZZSTOP"), 6'd11, 1'b0, 1'b0, 10'd0,    1'b1, CODE_ZZSTOP, 1'b0},
        '{ROW_FRAME, 128'({"LANYA_", "ZHUANGTAI"}), 6'd15, 1'b0, 1'b0, 10'd0, 1'b1,
          CODE_ZHUANGTAI, 1'b0},
        // unknown keyword, stray tail byte and a distance sample mid-payload
        '{ROW_FRAME, 128'("LANYA_X"),     6'd7,  1'b1, 1'b1, 10'd3,    1'b0, CODE_UNKNOWN,
          1'b0},
        // zero byte is an ordinary payload byte
        '{ROW_FRAME, 128'({"LANYA_W", 8'h00}), 6'd8, 1'b0, 1'b0, 10'd0, 1'b1, CODE_UNKNOWN,
          1'b0},
        '{ROW_FRAME, 128'(0),             6'd0,  1'b0, 1'b0, 10'd0,    1'b1, CODE_UNKNOWN,
          1'b0},
        '{ROW_LONG,  128'("A"),           6'd40, 1'b0, 1'b0, 10'd0,    1'b1, CODE_UNKNOWN,
          1'b1},
        // exactly full buffer is not overlong
        '{ROW_LONG,  128'("B"),           6'd32, 1'b0, 1'b0, 10'd0,    1'b1, CODE_UNKNOWN,
          1'b0}
    };

    // Decoder model state and its copy of the registers
    logic [DIST_W-1:0]  near_cfg, far_cfg;
    logic [SPEED_W-1:0] speed_normal_cfg, speed_max_cfg, speed_follow_cfg;
    t_phase             frame_state;
    logic [7:0]         payload_buf [PACKET_MAX];
    int                 payload_len;
    bit                 payload_overflow;
    logic [3:0]         steer;      // {right, left, back, fwd}
    bit                 stop_q, on_q, follow_q, brake_q;
    logic [SPEED_W-1:0] speed_q;

    t_result expected_responses [$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    int      stall_mode = 0;
    int      stall_left = 0;

    task automatic reset_decoder_model();
        near_cfg         = NEAR_RST;
        far_cfg          = FAR_RST;
        speed_normal_cfg = SPEED_NORMAL_RST;
        speed_max_cfg    = SPEED_MAX_RST;
        speed_follow_cfg = SPEED_FOLLOW_RST;
        frame_state      = PH_IDLE;
        payload_len      = 0;
        payload_overflow = 1'b0;
        steer            = '0;
        stop_q           = 1'b0;
        on_q             = 1'b0;
        follow_q         = 1'b0;
        brake_q          = 1'b0;
        speed_q          = SPEED_NORMAL_RST;
    endtask

    function automatic t_result snapshot_flags(input t_code code, input logic ovl);
        t_result r;
        r.code          = code;
        r.forward       = steer[0];
        r.backward      = steer[1];
        r.turn_left     = steer[2];
        r.turn_right    = steer[3];
        r.motor_stop    = stop_q;
        r.motor_on      = on_q;
        r.follow_mode   = follow_q;
        r.speed_level   = speed_q;
        r.brake_request = brake_q;
        r.overlong      = ovl;
        return r;
    endfunction

    // Exact length and bytes against each keyword in turn
    function automatic t_code lookup_keyword();
        bit hit;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (keyword_text[k].len() == payload_len) begin
                hit = 1'b1;
                for (int i = 0; i < payload_len; i++) begin
                    if (payload_buf[i] != keyword_text[k][i]) hit = 1'b0;
                end
                if (hit) return t_code'(k + 1);
            end
        end
        return CODE_UNKNOWN;
    endfunction

    // One accepted transaction through the decoder model; 1 when it yields a result
    function automatic bit advance_decoder(input logic cmd, input logic [7:0] rx,
                                           input logic [DIST_W-1:0] dist_cm,
                                           output t_result res);
        t_code code;
        res = '0;
        if (cmd) begin
            // follow mode: idle window first, then above far, then below near
            if (follow_q) begin
                if (dist_cm <= far_cfg && dist_cm >= near_cfg) steer = '0;
                else if (dist_cm > far_cfg) steer = STEER_FWD;
                else if (dist_cm < near_cfg) steer = STEER_BACK;
            end
            res = snapshot_flags(CODE_DISTANCE, 1'b0);
            return 1'b1;
        end
        case (frame_state)
            PH_BODY: begin
                if (rx == CH_HASH) begin
                    frame_state = PH_TAIL;
                end else if (payload_len < PACKET_MAX) begin
                    payload_buf[payload_len] = rx;
                    payload_len++;
                end else begin
                    payload_overflow = 1'b1;
                end
                return 1'b0;
            end
            PH_TAIL: begin
                if (rx != CH_LF) return 1'b0;
                frame_state = PH_IDLE;
                if (payload_overflow) begin
                    res = snapshot_flags(CODE_UNKNOWN, 1'b1);
                    return 1'b1;
                end
                code = lookup_keyword();
                case (code)
                    CODE_W:      steer = STEER_FWD;
                    CODE_S:      steer = STEER_BACK;
                    CODE_A:      steer = STEER_LEFT;
                    CODE_D:      steer = STEER_RGHT;
                    CODE_ON: begin
                        stop_q = 1'b0;
                        on_q   = 1'b1;
                    end
                    CODE_OFF: begin
                        stop_q = 1'b1;
                        on_q   = 1'b0;
                    end
                    CODE_SUDU1:  speed_q = speed_normal_cfg;
                    CODE_SUDU2:  speed_q = speed_max_cfg;
                    CODE_GENSUI: begin
                        follow_q = 1'b1;
                        speed_q  = speed_follow_cfg;
                    end
                    CODE_GENSUI_STOP: begin
                        follow_q = 1'b0;
                        speed_q  = speed_normal_cfg;
                        brake_q  = 1'b1;
                    end
                    CODE_STOP: begin
                        brake_q = 1'b1;
                        steer   = '0;
                    end
                    CODE_ZZSTOP: steer = '0;
                    default: ;
                endcase
                res = snapshot_flags(code, 1'b0);
                return 1'b1;
            end
            default: begin
                frame_state = PH_IDLE;
                if (rx == CH_AT) begin
                    frame_state      = PH_BODY;
                    payload_len      = 0;
                    payload_overflow = 1'b0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
    endtask

    task automatic check_response();
        t_result got, exp;
        got.code          = t_code'(o_response_code);
        got.forward       = o_forward;
        got.backward      = o_backward;
        got.turn_left     = o_turn_left;
        got.turn_right    = o_turn_right;
        got.motor_stop    = o_motor_stop;
        got.motor_on      = o_motor_on;
        got.follow_mode   = o_follow_mode;
        got.speed_level   = o_speed_level;
        got.brake_request = o_brake_request;
        got.overlong      = o_overlong;
        if (expected_responses.size() == 0) begin
            report_mismatch("result with none pending, code", 32'(got.code), 32'(0));
            return;
        end
        exp = expected_responses.pop_front();
        if (got.code !== exp.code)
            report_mismatch("response_code", 32'(got.code), 32'(exp.code));
        if (got.forward !== exp.forward)
            report_mismatch("forward", 32'(got.forward), 32'(exp.forward));
        if (got.backward !== exp.backward)
            report_mismatch("backward", 32'(got.backward), 32'(exp.backward));
        if (got.turn_left !== exp.turn_left)
            report_mismatch("turn_left", 32'(got.turn_left), 32'(exp.turn_left));
        if (got.turn_right !== exp.turn_right)
            report_mismatch("turn_right", 32'(got.turn_right), 32'(exp.turn_right));
        if (got.motor_stop !== exp.motor_stop)
            report_mismatch("motor_stop", 32'(got.motor_stop), 32'(exp.motor_stop));
        if (got.motor_on !== exp.motor_on)
            report_mismatch("motor_on", 32'(got.motor_on), 32'(exp.motor_on));
        if (got.follow_mode !== exp.follow_mode)
            report_mismatch("follow_mode", 32'(got.follow_mode), 32'(exp.follow_mode));
        if (got.speed_level !== exp.speed_level)
            report_mismatch("speed_level", 32'(got.speed_level), 32'(exp.speed_level));
        if (got.brake_request !== exp.brake_request)
            report_mismatch("brake_request", 32'(got.brake_request), 32'(exp.brake_request));
        if (got.overlong !== exp.overlong)
            report_mismatch("overlong", 32'(got.overlong), 32'(exp.overlong));
    endtask

    // Result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) check_response();
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Result-side stall: segments of no stall, light, heavy and periodic stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ((stall_left % 16) < 6);
        endcase
    end

    // Drive one input transaction, predict it on acceptance, then pace the sender
    task automatic send_item(input logic cmd, input logic [7:0] rx,
                             input logic [DIST_W-1:0] dist_cm, input logic typed,
                             input t_code code, input logic ovl);
        t_result res;
        int      gap;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_rx_byte     <= rx;
        i_distance_cm <= dist_cm;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (advance_decoder(cmd, rx, dist_cm, res)) begin
            if (typed) begin
                res.code     = code;
                res.overlong = ovl;
            end
            expected_responses.push_back(res);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(1'b0, rx, DIST_W'($urandom), 1'b0, CODE_UNKNOWN, 1'b0);
    endtask

    task automatic send_distance(input logic [DIST_W-1:0] dist_cm);
        send_item(1'b1, 8'($urandom), dist_cm, 1'b0, CODE_UNKNOWN, 1'b0);
    endtask

    // Whole frame; the typed code applies to the result of the closing line feed
    task automatic send_frame(input logic [7:0] body [$], input logic with_start,
                              input logic junk, input logic split,
                              input logic [DIST_W-1:0] split_dist, input logic typed,
                              input t_code code, input logic ovl);
        logic [7:0] junk_byte;
        if (with_start) send_byte(CH_AT);
        foreach (body[i]) begin
            if (split && i == body.size() / 2) send_distance(split_dist);
            send_byte(body[i]);
        end
        send_byte(CH_HASH);
        if (junk) begin
            do junk_byte = 8'($urandom); while (junk_byte == CH_LF);
            send_byte(junk_byte);
        end
        send_item(1'b0, CH_LF, DIST_W'($urandom), typed, code, ovl);
    endtask

    task automatic run_row(input t_stim_row row);
        logic [7:0] body [$];
        case (row.kind)
            ROW_BYTE: send_byte(row.text[7:0]);
            ROW_DIST: send_item(1'b1, 8'($urandom), row.dist_cm, row.typed, row.code,
                                row.ovl);
            default: begin
                for (int i = 0; i < int'(row.len); i++) begin
                    if (row.kind == ROW_LONG) body.push_back(row.text[7:0]);
                    else body.push_back(row.text[8*(int'(row.len)-1-i) +: 8]);
                end
                send_frame(body, 1'b1, row.junk, row.split, row.dist_cm, row.typed,
                           row.code, row.ovl);
            end
        endcase
    endtask

    // Distances cluster at the window edges, with extremes and uniform picks
    function automatic logic [DIST_W-1:0] pick_distance();
        int d;
        case ($urandom_range(0, 3))
            0:       d = int'(near_cfg) + int'($urandom_range(0, 4)) - 2;
            1:       d = int'(far_cfg) + int'($urandom_range(0, 4)) - 2;
            2:       d = ($urandom_range(0, 1) == 0) ? 0 : 1023;
            default: d = int'($urandom_range(0, 1023));
        endcase
        if (d < 0) d = 0;
        if (d > 1023) d = 1023;
        return DIST_W'(d);
    endfunction

    // One random sequence: distance samples, noise bytes, keyword frames, near misses and junk
    task automatic random_sequence();
        logic [7:0] body [$];
        int         sel, n, k;
        string      kw;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            n = $urandom_range(1, 6);
            repeat (n) send_distance(pick_distance());
            return;
        end
        if (sel < 27) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
            return;
        end
        k  = $urandom_range(0, KW_COUNT - 1);
        kw = keyword_text[k];
        for (int i = 0; i < kw.len(); i++) body.push_back(kw[i]);
        if (sel < 40) begin
            // near miss: one byte changed, one short, one long
            case ($urandom_range(0, 3))
                0:       body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(65, 90));
                1:       void'(body.pop_back());
                2:       body.push_back(8'($urandom));
                default: void'(body.pop_front());
            endcase
        end else if (sel < 48) begin
            body.delete();
            n = $urandom_range(0, 20);
            repeat (n) body.push_back(8'($urandom));
        end else if (sel < 54) begin
            // around and past the buffer capacity
            body.delete();
            n = $urandom_range(PACKET_MAX - 2, PACKET_MAX + 8);
            repeat (n) body.push_back(8'($urandom_range(65, 90)));
        end
        send_frame(body, sel >= 58, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0,
                   pick_distance(), 1'b0, CODE_UNKNOWN, 1'b0);
    endtask

    // Stop sending and wait until every pending result has been taken
    task automatic drain_pending();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [DIST_W-1:0] near_cm,
                                  input logic [DIST_W-1:0] far_cm,
                                  input logic [SPEED_W-1:0] s_normal,
                                  input logic [SPEED_W-1:0] s_max,
                                  input logic [SPEED_W-1:0] s_follow);
        t_cfg_idx              reg_idx [5] = '{CFG_NEAR, CFG_FAR, CFG_SPEED_NORMAL,
                                               CFG_SPEED_MAX, CFG_SPEED_FOLLOW};
        logic [CFG_DATA_W-1:0] reg_val [5];
        reg_val = '{near_cm, far_cm, CFG_DATA_W'(s_normal), CFG_DATA_W'(s_max),
                    CFG_DATA_W'(s_follow)};
        for (int r = 0; r < 5; r++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_idx[r];
            i_cfg_data  <= reg_val[r];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        near_cfg         = near_cm;
        far_cfg          = far_cm;
        speed_normal_cfg = s_normal;
        speed_max_cfg    = s_max;
        speed_follow_cfg = s_follow;
    endtask

    // Main sequence
    initial begin
        int                target;
        logic [DIST_W-1:0] lim;
        reset_decoder_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) run_row(directed_rows[r]);

        for (int p = 1; p <= 5; p++) begin
            drain_pending();
            case (p)
                1: write_settings(10'd0, 10'd1023, 4'd0, 4'd15, 4'd0);
                2: write_settings(10'd1023, 10'd0, 4'd15, 4'd0, 4'd15);
                3: begin
                    lim = DIST_W'($urandom);
                    write_settings(lim, lim, 4'($urandom), 4'($urandom), 4'($urandom));
                end
                4: write_settings(DIST_W'($urandom), DIST_W'($urandom), 4'($urandom),
                                  4'($urandom), 4'($urandom));
                default: begin
                    lim = DIST_W'($urandom_range(0, 60));
                    write_settings(lim, lim + DIST_W'($urandom_range(0, 30)), 4'($urandom),
                                   4'($urandom), 4'($urandom));
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_sequence();
        end

        drain_pending();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
